FILE: sv/rpk_pkg.sv
// Shared types, constants and helpers of the word to RGB pixel repacker.
// Used by the front, queue, back and top level modules; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rpk_pkg;

   localparam int WORD_WIDTH       = 32;
   localparam int PIXEL_WIDTH      = 24;
   localparam int PIXELS_PER_GROUP = 4;
   localparam int GROUP_WIDTH      = PIXEL_WIDTH * PIXELS_PER_GROUP;
   localparam int REG_WIDTH        = 12;
   localparam int COLUMN_WIDTH     = 10;
   localparam int PIXEL_IDX_WIDTH  = 2;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [REG_WIDTH-1:0] WIDTH_RESET  = 12'd1280;
   localparam logic [REG_WIDTH-1:0] HEIGHT_RESET = 12'd720;

   // Configuration register indexes.
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [PIXEL_IDX_WIDTH-1:0] LAST_PIXEL = 2'd3;

   // Word position inside a three-word group.
   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_SECOND = 3'b010,
      PH_THIRD  = 3'b100
   } phase_type;

   // One complete group of four pixels with its framing marks.
   typedef struct packed {
      logic [GROUP_WIDTH-1:0] bits;
      logic                   sof;
      logic                   eol;
   } group_type;

   // Pixel k is bits 24k+23 down to 24k of the group.
   function automatic logic [PIXEL_WIDTH-1:0] pick_pixel(
      input logic [GROUP_WIDTH-1:0]     bits,
      input logic [PIXEL_IDX_WIDTH-1:0] idx
   );
      pick_pixel = bits[PIXEL_WIDTH*idx +: PIXEL_WIDTH];
   endfunction

endpackage

`default_nettype wire

FILE: sv/word_to_rgb_pixel_repacker.sv
// Repacks 32-bit words into 24-bit pixels: every three words give four pixels.
// The first pixel of a group goes from its third word into the group queue and then
// into the output register, when the group queue and the output register are free.
// One pixel per cycle leaves the single output register while the output is not
// stalled and a group is queued.
// Words still enter one per cycle while the group queue has room.
// Reset (synchronous): empties the queue and output, restarts at frame start.
`timescale 1ns / 1ps
`default_nettype none

module word_to_rgb_pixel_repacker #(
   parameter int QueueDepth = rpk_pkg::QUEUE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [rpk_pkg::WORD_WIDTH-1:0]   req_packed_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [rpk_pkg::PIXEL_WIDTH-1:0]       rsp_pixel_value,
   output logic                                  rsp_start_of_frame,
   output logic                                  rsp_end_of_line,
   input  wire logic                             csr_write_enable,
   input  wire logic                             csr_index,
   input  wire logic [rpk_pkg::REG_WIDTH-1:0]    csr_write_data
);

   logic               push_valid;
   logic               push_ready;
   rpk_pkg::group_type push_data;
   logic               pop_valid;
   logic               pop_ready;
   rpk_pkg::group_type pop_data;

   rpk_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_packed_word  (req_packed_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   rpk_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rpk_back u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_start_of_frame (rsp_start_of_frame),
      .rsp_end_of_line    (rsp_end_of_line)
   );

endmodule

`default_nettype wire

FILE: sv/rpk_front.sv
// Front part: accepts packed words, holds the first two words of a group and
// tracks column, row and frame position. Depends on rpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpk_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [rpk_pkg::WORD_WIDTH-1:0]   req_packed_word,
   input  wire logic                             csr_write_enable,
   input  wire logic                             csr_index,
   input  wire logic [rpk_pkg::REG_WIDTH-1:0]    csr_write_data,
   output logic                                  push_valid,
   input  wire logic                             push_ready,
   output rpk_pkg::group_type                    push_data
);

   rpk_pkg::phase_type                   phase_ff, phase_in;
   logic [rpk_pkg::COLUMN_WIDTH-1:0]     column_ff, column_in;
   logic [rpk_pkg::REG_WIDTH-1:0]        row_ff, row_in;
   logic                                 pending_ff, pending_in;
   logic [rpk_pkg::REG_WIDTH-1:0]        width_ff, width_in;
   logic [rpk_pkg::REG_WIDTH-1:0]        height_ff, height_in;
   logic [rpk_pkg::WORD_WIDTH-1:0]       held0_ff, held0_in;
   logic [rpk_pkg::WORD_WIDTH-1:0]       held1_ff, held1_in;

   logic                                 accept;
   logic                                 third_word;
   logic [rpk_pkg::COLUMN_WIDTH:0]       column_next;
   logic [rpk_pkg::REG_WIDTH:0]          row_next;
   logic                                 row_end;
   logic                                 frame_end;

   assign third_word = (phase_ff == rpk_pkg::PH_THIRD);
   assign req_stall  = third_word && !push_ready;
   assign accept     = req_valid && !req_stall;

   // Groups per row is the width divided by four, rounded down.
   assign column_next = {1'b0, column_ff} + 11'd1;
   assign row_end     = column_next >= {1'b0, width_ff[rpk_pkg::REG_WIDTH-1:2]};
   assign row_next    = {1'b0, row_ff} + 13'd1;
   assign frame_end   = row_next >= {1'b0, height_ff};

   assign push_valid     = accept && third_word;
   assign push_data.bits = {req_packed_word, held1_ff, held0_ff};
   assign push_data.sof  = pending_ff;
   assign push_data.eol  = row_end;

   always_comb begin
      phase_in   = phase_ff;
      column_in  = column_ff;
      row_in     = row_ff;
      pending_in = pending_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      width_in   = width_ff;
      height_in  = height_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            rpk_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_write_data;
            rpk_pkg::CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
      end

      if (accept) begin
         unique case (phase_ff)
            rpk_pkg::PH_FIRST: begin
               held0_in = req_packed_word;
               phase_in = rpk_pkg::PH_SECOND;
            end
            rpk_pkg::PH_SECOND: begin
               held1_in = req_packed_word;
               phase_in = rpk_pkg::PH_THIRD;
            end
            rpk_pkg::PH_THIRD: begin
               phase_in   = rpk_pkg::PH_FIRST;
               pending_in = 1'b0;
               if (row_end) begin
                  column_in = '0;
                  if (frame_end) begin
                     row_in     = '0;
                     pending_in = 1'b1;
                  end else begin
                     row_in = row_next[rpk_pkg::REG_WIDTH-1:0];
                  end
               end else begin
                  column_in = column_next[rpk_pkg::COLUMN_WIDTH-1:0];
               end
            end
            default: phase_in = rpk_pkg::PH_FIRST;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rpk_pkg::PH_FIRST;
         column_ff  <= '0;
         row_ff     <= '0;
         pending_ff <= 1'b1;
         width_ff   <= rpk_pkg::WIDTH_RESET;
         height_ff  <= rpk_pkg::HEIGHT_RESET;
      end else begin
         phase_ff   <= phase_in;
         column_ff  <= column_in;
         row_ff     <= row_in;
         pending_ff <= pending_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

`default_nettype wire

FILE: sv/rpk_queue.sv
// Short queue of complete pixel groups between the front and back parts.
// Depends on rpk_pkg for the group type.
`timescale 1ns / 1ps
`default_nettype none

module rpk_queue #(
   parameter int QueueDepth = rpk_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire rpk_pkg::group_type push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output rpk_pkg::group_type      pop_data
);

   localparam int PTR_WIDTH = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CNT_WIDTH = $clog2(QueueDepth + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_SLOT = PTR_WIDTH'(QueueDepth - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(QueueDepth);

   rpk_pkg::group_type         slots_ff [QueueDepth];
   logic [PTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]       count_ff, count_in;
   logic                       do_push;
   logic                       do_pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/rpk_back.sv
// Back part: splits queued groups into four pixels each, one per cycle unless
// stalled, into an output register with framing marks. Depends on rpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rpk_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             pop_valid,
   output logic                                  pop_ready,
   input  wire rpk_pkg::group_type               pop_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [rpk_pkg::PIXEL_WIDTH-1:0]       rsp_pixel_value,
   output logic                                  rsp_start_of_frame,
   output logic                                  rsp_end_of_line
);

   logic [rpk_pkg::PIXEL_IDX_WIDTH-1:0]  idx_ff, idx_in;
   logic                                 valid_ff, valid_in;
   logic [rpk_pkg::PIXEL_WIDTH-1:0]      pixel_ff, pixel_in;
   logic                                 sof_ff, sof_in;
   logic                                 eol_ff, eol_in;
   logic                                 load;
   logic                                 last_pixel;

   // The output register takes a new pixel whenever a group is queued and it is empty or drained.
   assign load       = pop_valid && (!valid_ff || !rsp_stall);
   assign last_pixel = idx_ff == rpk_pkg::LAST_PIXEL;
   assign pop_ready  = load && last_pixel;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      pixel_in = pixel_ff;
      sof_in   = sof_ff;
      eol_in   = eol_ff;
      if (load) begin
         idx_in   = idx_ff + 1'b1;
         valid_in = 1'b1;
         pixel_in = rpk_pkg::pick_pixel(pop_data.bits, idx_ff);
         sof_in   = pop_data.sof && (idx_ff == '0);
         eol_in   = pop_data.eol && last_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      sof_ff   <= sof_in;
      eol_ff   <= eol_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_pixel_value    = pixel_ff;
   assign rsp_start_of_frame = sof_ff;
   assign rsp_end_of_line    = eol_ff;

endmodule

`default_nettype wire

FILE: sv/rpk_checker.sv
// Port-level checks of the word to RGB pixel repacker, bound to the top level.
// Depends on rpk_pkg and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module rpk_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [rpk_pkg::PIXEL_WIDTH-1:0]  rsp_pixel_value,
   input wire logic                             rsp_start_of_frame,
   input wire logic                             rsp_end_of_line
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A held result keeps its pixel.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_value))
      else $error("stalled result changed");

   // Start of frame is on the first pixel of a group, end of line on the last.
   a_marks_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_start_of_frame && rsp_end_of_line))
      else $error("start of frame and end of line on one pixel");

   // The pixel after a frame start belongs to the same group and is no start.
   a_sof_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_start_of_frame |=>
         !rsp_valid || !rsp_start_of_frame)
      else $error("two frame starts in a row");

endmodule

bind word_to_rgb_pixel_repacker rpk_checker u_rpk_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_pixel_value    (rsp_pixel_value),
   .rsp_start_of_frame (rsp_start_of_frame),
   .rsp_end_of_line    (rsp_end_of_line)
);

`default_nettype wire

FILE: test/repacker_checker.sv
// Checker for the word to RGB pixel repacker: watches the word, pixel and register
// ports, predicts the pixel stream and compares it transaction by transaction.
// Depends on rpk_pkg.
`timescale 1ns / 1ps

module repacker_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [rpk_pkg::WORD_WIDTH-1:0]  req_packed_word,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [rpk_pkg::PIXEL_WIDTH-1:0] rsp_pixel_value,
   input  logic                            rsp_start_of_frame,
   input  logic                            rsp_end_of_line,
   input  logic                            csr_write_enable,
   input  logic                            csr_index,
   input  logic [rpk_pkg::REG_WIDTH-1:0]   csr_write_data,
   output int                              mismatch_count,
   output int                              pixels_owed
);

   typedef struct packed {
      logic [rpk_pkg::PIXEL_WIDTH-1:0] value;
      logic                            sof;
      logic                            eol;
   } beat_type;

   beat_type                           expected_pixels[$];
   logic [rpk_pkg::REG_WIDTH-1:0]      width_reg;
   logic [rpk_pkg::REG_WIDTH-1:0]      height_reg;
   logic [rpk_pkg::WORD_WIDTH-1:0]     first_word;
   logic [rpk_pkg::WORD_WIDTH-1:0]     second_word;
   int                                 words_held;
   logic [rpk_pkg::COLUMN_WIDTH-1:0]   group_col;
   logic [rpk_pkg::REG_WIDTH-1:0]      row_idx;
   logic                               frame_pending;

   initial begin
      mismatch_count = 0;
      pixels_owed    = 0;
   end

   task automatic flag_mismatch(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
   endtask

   // Collects words into groups of three and queues the four pixels of each group.
   task automatic take_word(input logic [rpk_pkg::WORD_WIDTH-1:0] word);
      logic [rpk_pkg::GROUP_WIDTH-1:0] group;
      logic                            row_end;
      beat_type                        beat;
      if (words_held == 0) begin
         first_word = word;
         words_held = 1;
      end else if (words_held == 1) begin
         second_word = word;
         words_held  = 2;
      end else begin
         group   = {word, second_word, first_word};
         row_end = (int'(group_col) + 1) >= int'(width_reg >> 2);
         for (int k = 0; k < rpk_pkg::PIXELS_PER_GROUP; k++) begin
            beat.value = group[rpk_pkg::PIXEL_WIDTH*k +: rpk_pkg::PIXEL_WIDTH];
            beat.sof   = frame_pending;
            beat.eol   = row_end && (k == rpk_pkg::PIXELS_PER_GROUP - 1);
            expected_pixels.push_back(beat);
            frame_pending = 1'b0;
         end
         words_held = 0;
         // A height of zero ends the frame on every row, just like a height of one.
         if (row_end) begin
            group_col = '0;
            if (int'(row_idx) + 1 >= int'(height_reg)) begin
               row_idx       = '0;
               frame_pending = 1'b1;
            end else begin
               row_idx = row_idx + 1'b1;
            end
         end else begin
            group_col = group_col + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      beat_type got;
      beat_type want;
      if (reset) begin
         width_reg     = rpk_pkg::WIDTH_RESET;
         height_reg    = rpk_pkg::HEIGHT_RESET;
         words_held    = 0;
         group_col     = '0;
         row_idx       = '0;
         frame_pending = 1'b1;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == rpk_pkg::CSR_IMAGE_WIDTH) begin
               width_reg = csr_write_data;
            end else begin
               height_reg = csr_write_data;
            end
         end
         if (req_valid && !req_stall) begin
            take_word(req_packed_word);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pixel_value, rsp_start_of_frame, rsp_end_of_line};
            if (expected_pixels.size() == 0) begin
               flag_mismatch("unexpected pixel", '0, got.value);
            end else begin
               want = expected_pixels.pop_front();
               if (got.value !== want.value) flag_mismatch("pixel_value", want.value, got.value);
               if (got.sof !== want.sof) flag_mismatch("start_of_frame", want.sof, got.sof);
               if (got.eol !== want.eol) flag_mismatch("end_of_line", want.eol, got.eol);
            end
         end
      end
      pixels_owed = expected_pixels.size();
   end

endmodule

FILE: test/word_to_rgb_pixel_repacker_tb.sv
// Top of the repacker testbench: drives words, register writes and output stalls.
// Depends on rpk_pkg, the repacker RTL and repacker_checker.
`timescale 1ns / 1ps

module word_to_rgb_pixel_repacker_tb;

   localparam int WORD_W = rpk_pkg::WORD_WIDTH;
   localparam int PIXEL_W = rpk_pkg::PIXEL_WIDTH;
   localparam int REG_W = rpk_pkg::REG_WIDTH;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [WORD_W-1:0]      req_packed_word    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [PIXEL_W-1:0]     rsp_pixel_value;
   logic                   rsp_start_of_frame;
   logic                   rsp_end_of_line;
   logic                   csr_write_enable   = 1'b0;
   logic                   csr_index          = rpk_pkg::CSR_IMAGE_WIDTH;
   logic [REG_W-1:0]       csr_write_data     = '0;
   logic                   steady             = 1'b0;
   int                     mismatch_count;
   int                     pixels_owed;
   int                     words_sent         = 0;

   word_to_rgb_pixel_repacker i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packed_word   (req_packed_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_start_of_frame(rsp_start_of_frame),
      .rsp_end_of_line   (rsp_end_of_line),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   repacker_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_packed_word   (req_packed_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_start_of_frame(rsp_start_of_frame),
      .rsp_end_of_line   (rsp_end_of_line),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .pixels_owed       (pixels_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(99) < 21);
   end

   // Called and returns at a falling edge; the word is held until the transaction completes.
   task automatic send_word(input logic [WORD_W-1:0] word);
      while (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_packed_word <= word;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // Waits until every queued pixel has come out, then lets the pipeline drain.
   task automatic settle;
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pixels_owed != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
   endtask

   task automatic configure(input logic [REG_W-1:0] width, input logic [REG_W-1:0] height);
      csr_write_enable <= 1'b1;
      csr_index        <= rpk_pkg::CSR_IMAGE_WIDTH;
      csr_write_data   <= width;
      @(negedge clock);
      csr_index        <= rpk_pkg::CSR_IMAGE_HEIGHT;
      csr_write_data   <= height;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly small frames so that rows and frames wrap often.
   task automatic pick_frame(output logic [REG_W-1:0] width,
                             output logic [REG_W-1:0] height);
      case ($urandom_range(6))
         0: begin
            width  = 12'd4;
            height = 12'd1;
         end
         1: begin
            width  = 12'd4092;
            height = 12'd4095;
         end
         2: begin
            width  = REG_W'($urandom_range(3));
            height = REG_W'($urandom_range(2));
         end
         3: begin
            width  = REG_W'(4 * $urandom_range(1, 6));
            height = REG_W'($urandom_range(1, 4));
         end
         4: begin
            width  = REG_W'($urandom);
            height = REG_W'($urandom);
         end
         default: begin
            width  = REG_W'(4 * $urandom_range(1, 4));
            height = REG_W'($urandom_range(1, 3));
         end
      endcase
   endtask

   function automatic logic [WORD_W-1:0] any_word();
      case ($urandom_range(7))
         0:       any_word = '0;
         1:       any_word = '1;
         default: any_word = $urandom;
      endcase
   endfunction

   initial begin
      logic [REG_W-1:0] width;
      logic [REG_W-1:0] height;
      int               phase_words;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset frame size, with all-zero, all-one and alternating words.
      send_word(32'h0000_0000);
      send_word(32'hFFFF_FFFF);
      send_word(32'hAAAA_AAAA);
      send_word(32'h5555_5555);
      send_word(32'hFFFF_FFFF);
      send_word(32'h0000_0000);
      settle;
      // Width below four and height zero: every group ends its row and the frame.
      configure(12'd0, 12'd0);
      repeat (3) send_word($urandom);
      settle;
      // Width that is not a multiple of four, both registers at all ones.
      configure(12'd4095, 12'd4095);
      repeat (3) send_word($urandom);
      settle;
      // Two groups per row and two rows per frame, so the frame wraps.
      configure(12'd8, 12'd2);
      repeat (12) send_word(any_word());

      while (words_sent < 250) begin
         settle;
         if ($urandom_range(3) != 0) begin
            pick_frame(width, height);
            configure(width, height);
         end
         phase_words = $urandom_range(9, 45);
         repeat (phase_words) begin
            steady <= (words_sent >= 110 && words_sent < 170);
            send_word(any_word());
         end
      end
      steady <= 1'b0;
      settle;

      if (mismatch_count == 0 && pixels_owed == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
